/* rtl/gsr_pkg.sv */
// gsr_pkg: shared types and constants for the gptp sync receive block
`default_nettype none

package gsr_pkg;

  // message kind carried with each input transaction
  typedef enum logic [1:0] {
    CMD_TICK      = 2'd0,
    CMD_SYNC      = 2'd1,
    CMD_FOLLOW_UP = 2'd2
  } cmd_t;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PORT_OPER       = 3'd0,
    REG_PORT_ENABLED    = 3'd1,
    REG_AS_CAPABLE      = 3'd2,
    REG_ASYMMETRY_MODE  = 3'd3,
    REG_BEGIN_FORCE     = 3'd4,
    REG_INSTANCE_ENABLE = 3'd5,
    REG_MEAN_LINK_DELAY = 3'd6,
    REG_FU_TIMEOUT      = 3'd7
  } cfg_reg_t;

  localparam int unsigned CFG_DATA_W = 64;

  // one second in 2^-16 ns units
  localparam logic [63:0] FU_TIMEOUT_RESET = 64'd65536000000000;

  // receive state machine, one-hot
  typedef enum logic [2:0] {
    ST_DISCARD   = 3'b001,
    ST_WAIT_FU   = 3'b010,
    ST_WAIT_SYNC = 3'b100
  } state_t;

  // single-bit configuration flags
  typedef struct packed {
    logic port_oper;
    logic port_enabled;
    logic as_capable;
    logic asymmetry_mode;
    logic begin_force;
    logic instance_enable;
  } cfg_flags_t;

  // input transaction
  typedef struct packed {
    logic [1:0]         cmd;
    logic [63:0]        now;
    logic [15:0]        seq_id;
    logic [63:0]        correction;
    logic [63:0]        ingress_time;
    logic [63:0]        clock_identity;
    logic [15:0]        source_port;
    logic signed [7:0]  log_interval;
    logic [7:0]         domain;
    logic [47:0]        origin_seconds;
    logic [29:0]        origin_nanoseconds;
    logic [15:0]        gm_base_indicator;
  } in_item_t;

  // result transaction
  typedef struct packed {
    logic [63:0]        total_correction;
    logic [63:0]        upstream_tx_time;
    logic [63:0]        out_clock_identity;
    logic [15:0]        out_source_port;
    logic signed [7:0]  out_log_interval;
    logic [7:0]         out_domain;
    logic [47:0]        out_origin_seconds;
    logic [29:0]        out_origin_nanoseconds;
    logic [15:0]        out_gm_base_indicator;
  } out_item_t;

endpackage

`default_nettype wire

/* rtl/gptp_sync_receive_fsm.sv */
// gptp_sync_receive_fsm: two-step gptp sync receive, top level
//
//  channel  direction  handshake             payload
//  in       input      in_valid / in_ready   in_data (gsr_pkg::in_item_t)
//  out      output     out_valid / out_ready out_data (gsr_pkg::out_item_t)
//  cfg      input      cfg_we                cfg_index, cfg_wdata
//
// one transaction per cycle unless the output stalls; a record is valid once its input
// transaction passes the input register, then settling logic into the result register
// the core's settling path is one time add, a deadline compare and a sequence match
// reset is synchronous: state machine in discard, configuration registers at defaults
// a stalled output holds the core and input register; if full, ready follows the slot
`default_nettype none

module gptp_sync_receive_fsm #(
  parameter int unsigned TIME_BITS = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire gsr_pkg::in_item_t                   in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output gsr_pkg::out_item_t                       out_data,
  input  wire logic                                cfg_we,
  input  wire logic [gsr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [gsr_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import gsr_pkg::*;

  cfg_flags_t           flags;
  logic [TIME_BITS-1:0] mean_link_delay;
  logic [TIME_BITS-1:0] follow_up_timeout;

  logic      item_valid;
  in_item_t  item;
  logic      slot_free;
  logic      core_fire;
  logic      res_valid;
  out_item_t res_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      flags.port_oper       <= 1'b0;
      flags.port_enabled    <= 1'b0;
      flags.as_capable      <= 1'b0;
      flags.asymmetry_mode  <= 1'b0;
      flags.begin_force     <= 1'b0;
      flags.instance_enable <= 1'b1;
      mean_link_delay       <= '0;
      follow_up_timeout     <= FU_TIMEOUT_RESET[TIME_BITS-1:0];
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PORT_OPER:       flags.port_oper       <= cfg_wdata[0];
        REG_PORT_ENABLED:    flags.port_enabled    <= cfg_wdata[0];
        REG_AS_CAPABLE:      flags.as_capable      <= cfg_wdata[0];
        REG_ASYMMETRY_MODE:  flags.asymmetry_mode  <= cfg_wdata[0];
        REG_BEGIN_FORCE:     flags.begin_force     <= cfg_wdata[0];
        REG_INSTANCE_ENABLE: flags.instance_enable <= cfg_wdata[0];
        REG_MEAN_LINK_DELAY: mean_link_delay       <= cfg_wdata[TIME_BITS-1:0];
        REG_FU_TIMEOUT:      follow_up_timeout     <= cfg_wdata[TIME_BITS-1:0];
        default:             ;
      endcase
    end
  end

  // input register
  gsr_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .take       (slot_free),
    .item_valid (item_valid),
    .item       (item)
  );

  assign core_fire = item_valid && slot_free;

  // settling logic and message state
  gsr_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk               (clk),
    .rst               (rst),
    .fire              (core_fire),
    .item              (item),
    .flags             (flags),
    .mean_link_delay   (mean_link_delay),
    .follow_up_timeout (follow_up_timeout),
    .res_valid         (res_valid),
    .res_data          (res_data)
  );

  // result register
  gsr_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .load_data (res_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .free      (slot_free)
  );

  // an empty result slot never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty result slot");

  // a new record only follows a transaction leaving the input register
  a_record_has_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(core_fire))
    else $error("record produced without a transaction");

  // forced discard never produces a record
  a_no_record_in_begin: assert property (@(posedge clk) disable iff (rst)
    (core_fire && flags.begin_force) |-> !res_valid)
    else $error("record produced while begin is forced");

endmodule

`default_nettype wire

/* rtl/gsr_in_reg.sv */
// gsr_in_reg: input register stage holding one transaction for the core
`default_nettype none

module gsr_in_reg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire gsr_pkg::in_item_t in_data,
  input  wire logic             take,
  output logic                  item_valid,
  output gsr_pkg::in_item_t     item
);
  import gsr_pkg::*;

  // free when empty or when the held transaction moves on this cycle
  assign in_ready = !item_valid || take;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
  end

endmodule

`default_nettype wire

/* rtl/gsr_core.sv */
// gsr_core: message latches, settling state machine and record assembly
`default_nettype none

module gsr_core #(
  parameter int unsigned TIME_BITS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               fire,
  input  wire gsr_pkg::in_item_t  item,
  input  wire gsr_pkg::cfg_flags_t flags,
  input  wire logic [TIME_BITS-1:0] mean_link_delay,
  input  wire logic [TIME_BITS-1:0] follow_up_timeout,
  output logic                    res_valid,
  output gsr_pkg::out_item_t      res_data
);
  import gsr_pkg::*;

  // control state
  state_t state, state_next;
  logic   sync_pending, sync_pending_next;
  logic   followup_pending, followup_pending_next;

  // latched message fields
  logic [15:0]          sync_seq, sync_seq_next;
  logic [63:0]          sync_corr, sync_corr_next;
  logic [TIME_BITS-1:0] sync_ingress, sync_ingress_next;
  logic [63:0]          sync_clock_id, sync_clock_id_next;
  logic [15:0]          sync_port, sync_port_next;
  logic signed [7:0]    sync_log_interval, sync_log_interval_next;
  logic [7:0]           sync_domain, sync_domain_next;
  logic [15:0]          fu_seq, fu_seq_next;
  logic [63:0]          fu_correction, fu_correction_next;
  logic [47:0]          fu_origin_sec, fu_origin_sec_next;
  logic [29:0]          fu_origin_ns, fu_origin_ns_next;
  logic [15:0]          fu_gm_indicator, fu_gm_indicator_next;
  logic [TIME_BITS-1:0] timeout_deadline, timeout_deadline_next;

  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] rearm_deadline;
  logic [TIME_BITS-1:0] deadline_eff;
  logic [TIME_BITS-1:0] upstream;
  logic                 sync_in;
  logic                 fu_in;
  logic                 port_valid;
  logic                 abort;
  logic                 enter_wait_fu;
  logic                 eval_wait_fu;
  logic                 seq_match;
  logic                 timed_out;
  logic                 emit;

  assign now_t = item.now[TIME_BITS-1:0];

  // decode message kind, reserved code acts as a tick
  always_comb begin
    sync_in = 1'b0;
    fu_in   = 1'b0;
    case (item.cmd)
      CMD_SYNC:      sync_in = 1'b1;
      CMD_FOLLOW_UP: fu_in   = 1'b1;
      default:       ;
    endcase
  end

  // latch the incoming message ahead of settling
  always_comb begin
    sync_seq_next          = sync_seq;
    sync_corr_next         = sync_corr;
    sync_ingress_next      = sync_ingress;
    sync_clock_id_next     = sync_clock_id;
    sync_port_next         = sync_port;
    sync_log_interval_next = sync_log_interval;
    sync_domain_next       = sync_domain;
    fu_seq_next            = fu_seq;
    fu_correction_next     = fu_correction;
    fu_origin_sec_next     = fu_origin_sec;
    fu_origin_ns_next      = fu_origin_ns;
    fu_gm_indicator_next   = fu_gm_indicator;
    if (sync_in) begin
      sync_seq_next          = item.seq_id;
      sync_corr_next         = item.correction;
      sync_ingress_next      = item.ingress_time[TIME_BITS-1:0];
      sync_clock_id_next     = item.clock_identity;
      sync_port_next         = item.source_port;
      sync_log_interval_next = item.log_interval;
      sync_domain_next       = item.domain;
    end
    if (fu_in) begin
      fu_seq_next          = item.seq_id;
      fu_correction_next   = item.correction;
      fu_origin_sec_next   = item.origin_seconds;
      fu_origin_ns_next    = item.origin_nanoseconds;
      fu_gm_indicator_next = item.gm_base_indicator;
    end
  end

  // settled transition for one transaction
  logic sync_flag;
  logic fu_flag;
  assign sync_flag  = sync_pending || sync_in;
  assign fu_flag    = followup_pending || fu_in;
  assign port_valid = flags.port_oper && flags.port_enabled && flags.as_capable;
  assign abort      = flags.begin_force || !flags.instance_enable ||
                      (sync_flag && !port_valid);

  // a sync pending here implies a valid port, else the abort path is taken
  assign enter_wait_fu  = !abort && sync_flag &&
                          ((state == ST_WAIT_FU) || !flags.asymmetry_mode);
  assign eval_wait_fu   = !abort && (enter_wait_fu || (state == ST_WAIT_FU));
  assign rearm_deadline = now_t + follow_up_timeout;
  assign deadline_eff   = enter_wait_fu ? rearm_deadline : timeout_deadline;
  assign seq_match      = fu_flag && (fu_seq_next == sync_seq_next);
  assign timed_out      = (now_t >= deadline_eff) && !flags.asymmetry_mode;
  assign emit           = eval_wait_fu && seq_match;

  always_comb begin
    state_next            = state;
    sync_pending_next     = sync_flag;
    followup_pending_next = fu_flag;
    timeout_deadline_next = deadline_eff;
    if (abort) begin
      state_next            = ST_DISCARD;
      sync_pending_next     = 1'b0;
      followup_pending_next = 1'b0;
    end else if (eval_wait_fu) begin
      sync_pending_next = 1'b0;
      if (seq_match) begin
        state_next            = ST_WAIT_SYNC;
        followup_pending_next = 1'b0;
      end else if (timed_out) begin
        state_next            = ST_DISCARD;
        followup_pending_next = 1'b0;
      end else begin
        state_next = ST_WAIT_FU;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_DISCARD;
      sync_pending     <= 1'b0;
      followup_pending <= 1'b0;
    end else if (fire) begin
      state            <= state_next;
      sync_pending     <= sync_pending_next;
      followup_pending <= followup_pending_next;
    end
  end

  // message field registers
  always_ff @(posedge clk) begin
    if (fire) begin
      sync_seq          <= sync_seq_next;
      sync_corr         <= sync_corr_next;
      sync_ingress      <= sync_ingress_next;
      sync_clock_id     <= sync_clock_id_next;
      sync_port         <= sync_port_next;
      sync_log_interval <= sync_log_interval_next;
      sync_domain       <= sync_domain_next;
      fu_seq            <= fu_seq_next;
      fu_correction     <= fu_correction_next;
      fu_origin_sec     <= fu_origin_sec_next;
      fu_origin_ns      <= fu_origin_ns_next;
      fu_gm_indicator   <= fu_gm_indicator_next;
      timeout_deadline  <= timeout_deadline_next;
    end
  end

  // record built from the freshly latched fields
  assign upstream  = sync_ingress_next - mean_link_delay;
  assign res_valid = fire && emit;

  always_comb begin
    res_data.total_correction       = sync_corr_next + fu_correction_next;
    res_data.upstream_tx_time       = 64'(upstream);
    res_data.out_clock_identity     = sync_clock_id_next;
    res_data.out_source_port        = sync_port_next;
    res_data.out_log_interval       = sync_log_interval_next;
    res_data.out_domain             = sync_domain_next;
    res_data.out_origin_seconds     = fu_origin_sec_next;
    res_data.out_origin_nanoseconds = fu_origin_ns_next;
    res_data.out_gm_base_indicator  = fu_gm_indicator_next;
  end

endmodule

`default_nettype wire

/* rtl/gsr_out_reg.sv */
// gsr_out_reg: result register holding one record until taken
`default_nettype none

module gsr_out_reg (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,
  input  wire gsr_pkg::out_item_t load_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output gsr_pkg::out_item_t      out_data,
  output logic                    free
);
  import gsr_pkg::*;

  // slot can take a record when empty or emptied this cycle
  assign free = !out_valid || out_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= load_data;
    end
  end

endmodule

`default_nettype wire
